FILE: rtl/ray_box_slab_intersect_top_macros.svh
// Assertion macros shared by the ray/box checker.
// Include this file by bare name; it has no other dependency.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH

// same-cycle implication under reset
`define RBSI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under reset
`define RBSI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/rbsi_pkg.sv
// Types, constants and register codes of the ray/box slab test.
// No dependencies; used by every module of the block.
package rbsi_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 37;
  localparam int DIR_W      = 18;
  localparam int DIST_W     = 24;
  localparam int NUM_W      = POS_W + 1 + FRAC_BITS;
  localparam int QB         = DIST_W + 1;
  localparam int QW         = DIST_W + 2;
  localparam int DIV_LAT    = QB + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int ZERO_LIM   = ((1 << FRAC_BITS) + 999999) / 1000000;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_BITS    = 6 * POS_W + DIST_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = DIST_W + 3;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Z = 3'd5,
    FACE_POS_Z = 3'd6
  } face_e;

  typedef struct packed {
    logic [2:0][POS_W-1:0] origin;
    logic [2:0][DIR_W-1:0] dir;
  } ray_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] limit;
    logic              zmiss;
    logic [2:0]        zdir;
    logic [2:0]        dpos;
  } side_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num_lo;
    logic [2:0][NUM_W-1:0] num_hi;
    logic [2:0][DIR_W-1:0] dir;
    side_t                 side;
  } item_t;

endpackage

FILE: rtl/rbsi_front.sv
// Front stage: takes a box word, forms slab numerators and zero-axis checks.
// Depends on rbsi_pkg.
module rbsi_front import rbsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ray_cfg_t             cfg_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic                 full_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic  valid_q;
  item_t item_q, item_d;
  logic  accept;

  assign push_o          = valid_q && !full_i;
  assign s_axis_tready_o = !valid_q || !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign item_o          = item_q;

  always_comb begin
    logic [POS_W-1:0] lo, hi, org;
    logic [DIR_W-1:0] d, dmag;
    logic [POS_W:0]   dlo, dhi;
    logic             zero;
    item_d = '0;
    item_d.side.limit = s_axis_tdata_i[6*POS_W +: DIST_W];
    for (int a = 0; a < 3; a++) begin
      lo   = s_axis_tdata_i[a*POS_W +: POS_W];
      hi   = s_axis_tdata_i[(a+3)*POS_W +: POS_W];
      org  = cfg_i.origin[a];
      d    = cfg_i.dir[a];
      dlo  = {lo[POS_W-1], lo} - {org[POS_W-1], org};
      dhi  = {hi[POS_W-1], hi} - {org[POS_W-1], org};
      dmag = d[DIR_W-1] ? (~d + DIR_W'(1)) : d;
      zero = dmag < DIR_W'(ZERO_LIM);
      item_d.num_lo[a]   = {dlo, {FRAC_BITS{1'b0}}};
      item_d.num_hi[a]   = {dhi, {FRAC_BITS{1'b0}}};
      item_d.dir[a]      = d;
      item_d.side.zdir[a] = zero;
      item_d.side.dpos[a] = !d[DIR_W-1] && (d != '0);
      if (zero && (($signed(org) < $signed(lo)) || ($signed(org) > $signed(hi)))) begin
        item_d.side.zmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: rtl/rbsi_fifo.sv
// Short queue between the front stage and the divider pipeline.
// Depends on rbsi_pkg.
module rbsi_fifo import rbsi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FIFO_AW'(1);
      if (pop_i)  rd_q <= rd_q + FIFO_AW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/rbsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating output.
// Depends on rbsi_pkg.
module rbsi_div import rbsi_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIR_W-1:0] den_i,
  output logic [QW-1:0]    q_o
);

  logic [DIR_W-1:0] r_q    [QB+1];
  logic [QB-1:0]    low_q  [QB];
  logic [QB-1:0]    qb_q   [QB+1];
  logic [DIR_W-1:0] dmag_q [QB+1];
  logic             neg_q  [QB+1];
  logic             ovf_q  [QB+1];
  logic [QW-1:0]    q_q;

  logic [NUM_W-1:0]  nmag;
  logic [DIR_W-1:0]  dmag;
  logic [NUM_W-QB-1:0] top_part;
  logic              ovf0;

  logic [QB-1:0] mag;
  logic [QW-1:0] q_d;

  assign nmag     = num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;
  assign dmag     = den_i[DIR_W-1] ? (~den_i + DIR_W'(1)) : den_i;
  assign top_part = nmag[NUM_W-1:QB];
  assign ovf0     = top_part >= (NUM_W-QB)'(dmag);

  logic [DIR_W-1:0] r_d  [QB+1];
  logic [QB-1:0]    qb_d [QB+1];

  always_comb begin
    logic [DIR_W:0] t;
    logic           ge;
    r_d[0]  = '0;
    qb_d[0] = '0;
    for (int k = 0; k < QB; k++) begin
      t  = {r_q[k], low_q[k][QB-1]};
      ge = t >= {1'b0, dmag_q[k]};
      r_d[k+1]  = ge ? DIR_W'(t - {1'b0, dmag_q[k]}) : t[DIR_W-1:0];
      qb_d[k+1] = {qb_q[k][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= ovf0 ? '0 : top_part[DIR_W-1:0];
      low_q[0]  <= nmag[QB-1:0];
      qb_q[0]   <= '0;
      dmag_q[0] <= dmag;
      neg_q[0]  <= num_i[NUM_W-1] ^ den_i[DIR_W-1];
      ovf_q[0]  <= ovf0;
      for (int k = 0; k < QB; k++) begin
        r_q[k+1]    <= r_d[k+1];
        qb_q[k+1]   <= qb_d[k+1];
        dmag_q[k+1] <= dmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        if (k < QB-1) begin
          low_q[k+1] <= {low_q[k][QB-2:0], 1'b0};
        end
      end
      q_q <= q_d;
    end
  end

  always_comb begin
    if (ovf_q[QB] || (qb_q[QB] > QB'(1) << DIST_W)) begin
      mag = QB'(1) << DIST_W;
    end else begin
      mag = qb_q[QB];
    end
    q_d = neg_q[QB] ? (~{1'b0, mag} + QW'(1)) : {1'b0, mag};
  end

  assign q_o = q_q;

endmodule

FILE: rtl/rbsi_back.sv
// Back end: six dividers, slab ordering, near/far reduction, output register.
// Depends on rbsi_pkg and rbsi_div.
module rbsi_back import rbsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o
);

  logic en;
  logic out_v_q;

  assign en    = !out_v_q || m_axis_tready_i;
  assign pop_o = en && !empty_i;

  logic [2:0][QW-1:0] q_lo, q_hi;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (item_i.num_lo[a]),
      .den_i (item_i.dir[a]),
      .q_o   (q_lo[a])
    );
    rbsi_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (item_i.num_hi[a]),
      .den_i (item_i.dir[a]),
      .q_o   (q_hi[a])
    );
  end

  logic  sv_q [DIV_LAT];
  side_t sd_q [DIV_LAT];

  // order stage
  logic               ord_v_q;
  side_t              ord_sd_q;
  logic [2:0][QW-1:0] near_in_q, far_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_LAT; s++) sv_q[s] <= 1'b0;
      ord_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sv_q[0] <= !empty_i;
      for (int s = 1; s < DIV_LAT; s++) sv_q[s] <= sv_q[s-1];
      ord_v_q <= sv_q[DIV_LAT-1];
      out_v_q <= ord_v_q;
    end
  end

  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic                  hit_q, hit_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= item_i.side;
      for (int s = 1; s < DIV_LAT; s++) sd_q[s] <= sd_q[s-1];
      ord_sd_q <= sd_q[DIV_LAT-1];
      for (int a = 0; a < 3; a++) begin
        if ($signed(q_lo[a]) > $signed(q_hi[a])) begin
          near_in_q[a] <= q_hi[a];
          far_in_q[a]  <= q_lo[a];
        end else begin
          near_in_q[a] <= q_lo[a];
          far_in_q[a]  <= q_hi[a];
        end
      end
      data_q <= data_d;
      hit_q  <= hit_d;
    end
  end

  function automatic face_e face_code(input int axis, input logic dpos);
    face_e f;
    unique case (axis)
      0:       f = dpos ? FACE_NEG_X : FACE_POS_X;
      1:       f = dpos ? FACE_NEG_Y : FACE_POS_Y;
      default: f = dpos ? FACE_NEG_Z : FACE_POS_Z;
    endcase
    return f;
  endfunction

  always_comb begin
    logic signed [QW-1:0] near_v, far_v;
    face_e                face;
    near_v = '0;
    far_v  = $signed({2'b00, ord_sd_q.limit});
    face   = FACE_NONE;
    for (int a = 0; a < 3; a++) begin
      if (!ord_sd_q.zdir[a]) begin
        if ($signed(near_in_q[a]) > near_v) begin
          near_v = $signed(near_in_q[a]);
          face   = face_code(a, ord_sd_q.dpos[a]);
        end
        if ($signed(far_in_q[a]) < far_v) begin
          far_v = $signed(far_in_q[a]);
        end
      end
    end
    // near only grows and far only shrinks, so one final check covers all axes
    hit_d  = !ord_sd_q.zmiss && !(near_v > far_v);
    data_d = '0;
    if (hit_d) begin
      data_d[OUT_BITS-1:0] = {face, near_v[DIST_W-1:0]};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = hit_q;

endmodule

FILE: rtl/ray_box_slab_intersect_top.sv
// Top level of the ray/box slab test: ray registers, front, queue, back end.
// Depends on rbsi_pkg, rbsi_front, rbsi_fifo, rbsi_back.
//
// Usage: write the ray origin (indexes 0..2) and unit direction (3..5)
// through the cfg port while the block is idle, then stream boxes on the
// s_axis channel. Each box word yields exactly one result word on m_axis:
// tuser carries the hit flag, tdata the entry distance and face code.
// Throughput: one box per cycle, sustained, with tready high on both sides.
// Path from an accepted box to its result: the front register, the queue,
// the divider pipeline (one quotient bit per stage over 25 bits), an
// ordering stage and the reduction into the output register.
// Reset clears all valid flags and the queue, sets the origin to zero and
// the direction to +x. When the receiver drops tready, the output word
// holds and the back pipeline freezes; the queue of four absorbs what the
// front has taken, after which s_axis_tready_o falls.
module ray_box_slab_intersect_top import rbsi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [POS_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // limit_distance, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // entry_distance, face, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // hit
  output logic                  m_axis_tuser_o
);

  localparam ray_cfg_t CFG_RST = '{
    origin: '0,
    dir:    {DIR_W'(0), DIR_W'(0), DIR_W'(1 << FRAC_BITS)}
  };

  ray_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORG_X: cfg_q.origin[0] <= cfg_data_i;
        CFG_ORG_Y: cfg_q.origin[1] <= cfg_data_i;
        CFG_ORG_Z: cfg_q.origin[2] <= cfg_data_i;
        CFG_DIR_X: cfg_q.dir[0]    <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Y: cfg_q.dir[1]    <= cfg_data_i[DIR_W-1:0];
        CFG_DIR_Z: cfg_q.dir[2]    <= cfg_data_i[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  item_t front_item, head_item;
  logic  push, pop, full, empty;

  rbsi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (front_item)
  );

  rbsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  rbsi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .item_i          (head_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

FILE: rtl/rbsi_checker.sv
// Port-level checks of the ray/box slab test, bound to the top level.
// Depends on rbsi_pkg and ray_box_slab_intersect_top_macros.svh.
`include "ray_box_slab_intersect_top_macros.svh"

module rbsi_checker import rbsi_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  logic [2:0] face;
  assign face = m_axis_tdata_o[DIST_W +: 3];

  `RBSI_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `RBSI_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0)
  `RBSI_ASSERT_IMP(a_face_range, clk_i, rst_ni, m_axis_tvalid_o, face <= 3'(FACE_POS_Z))
  `RBSI_ASSERT_IMP(a_face_dist, clk_i, rst_ni, m_axis_tvalid_o && face != 3'(FACE_NONE), m_axis_tdata_o[DIST_W-1:0] != '0)

endmodule

bind ray_box_slab_intersect_top rbsi_checker u_rbsi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: verif/tb.sv
// Self-checking bench for ray_box_slab_intersect_top: streams boxes against several
// ray settings and checks each result word against a slab-test predictor.
// Depends on rbsi_pkg and the RTL of the block; needs nothing else.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbsi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int  STALL_LIMIT = 5000;
  localparam int  DRAIN_CYCLES = 40;
  localparam longint POS_MAX = 64'sd65529446400;
  localparam longint QCLAMP = 64'sd16777216;

  typedef struct packed {
    logic [DIST_W-1:0] limit;
    logic [POS_W-1:0]  max_z, max_y, max_x, min_z, min_y, min_x;
  } box_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] entry_dist;
    logic [2:0]        face;
  } hit_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [POS_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  ray_box_slab_intersect_top u_top (.*);

  box_t   box_pending[$];
  hit_t   hit_expected[$];
  box_t   box_cur;
  longint ray_org[3];
  longint ray_dir[3];
  int     send_gap = 0, recv_gap = 0, hold_off = 0;
  int     send_mode = 0, recv_mode = 0;
  int     mismatches = 0, boxes_sent = 0, results_seen = 0, hits_seen = 0;
  int     quiet_cycles = 0;
  bit     in_acc, out_acc;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic longint slab_t(longint bound, longint org, longint dir);
    longint q;
    q = ((bound - org) * 64'sd65536) / dir;
    if (q > QCLAMP) q = QCLAMP;
    if (q < -QCLAMP) q = -QCLAMP;
    return q;
  endfunction

  function automatic hit_t slab_predict(box_t b);
    logic signed [POS_W-1:0] lo_s[3], hi_s[3];
    longint lo, hi, ta, tb2, tmp, near_t, far_t;
    logic [2:0] face;
    hit_t r;
    lo_s[0] = b.min_x; lo_s[1] = b.min_y; lo_s[2] = b.min_z;
    hi_s[0] = b.max_x; hi_s[1] = b.max_y; hi_s[2] = b.max_z;
    near_t = 0;
    far_t = longint'({40'd0, b.limit});
    face = FACE_NONE;
    r = '0;
    for (int ax = 0; ax < 3; ax++) begin
      lo = longint'(lo_s[ax]);
      hi = longint'(hi_s[ax]);
      if (ray_dir[ax] == 0) begin
        // parallel to the slab: only the origin position matters
        if (ray_org[ax] < lo || ray_org[ax] > hi) return r;
        continue;
      end
      ta = slab_t(lo, ray_org[ax], ray_dir[ax]);
      tb2 = slab_t(hi, ray_org[ax], ray_dir[ax]);
      if (ta > tb2) begin
        tmp = ta; ta = tb2; tb2 = tmp;
      end
      if (ta > near_t) begin
        near_t = ta;
        face = 3'(2 * ax + (ray_dir[ax] > 0 ? 1 : 2));
      end
      if (tb2 < far_t) far_t = tb2;
      if (near_t > far_t) return r;
    end
    r.hit = 1'b1;
    r.entry_dist = near_t[DIST_W-1:0];
    r.face = face;
    return r;
  endfunction

  // Driver: hold the word until taken, then idle for the drawn gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid_i && !in_acc)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (box_pending.size() > 0) begin
        box_cur = box_pending.pop_front();
        s_axis_tdata_i <= IN_DATA_W'(box_cur);
        s_axis_tvalid_i <= 1'b1;
        send_gap = draw_gap(send_mode);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      m_axis_tready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Monitor: predict on input acceptance, compare on output acceptance.
  always @(posedge clk_i) begin
    hit_t got, want;
    in_acc = s_axis_tvalid_i && s_axis_tready_o;
    out_acc = m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni) begin
      if (in_acc) begin
        hit_expected.push_back(slab_predict(box_cur));
        boxes_sent++;
      end
      if (out_acc) begin
        got.hit = m_axis_tuser_o;
        got.entry_dist = m_axis_tdata_o[DIST_W-1:0];
        got.face = m_axis_tdata_o[DIST_W+2:DIST_W];
        results_seen++;
        if (got.hit) hits_seen++;
        if (hit_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: hit=%0d dist=%0d face=%0d",
                     got.hit, got.entry_dist, got.face);
        end else begin
          want = hit_expected.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected hit=%0d dist=%0d face=%0d, got hit=%0d dist=%0d face=%0d",
                       results_seen, want.hit, want.entry_dist, want.face,
                       got.hit, got.entry_dist, got.face);
          end
        end
        recv_gap = draw_gap(recv_mode);
      end
      quiet_cycles = (in_acc || out_acc) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint value);
    logic signed [POS_W-1:0] p;
    logic signed [DIR_W-1:0] d;
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[POS_W-1:0];
    p = value[POS_W-1:0];
    d = value[DIR_W-1:0];
    if (idx <= CFG_ORG_Z) ray_org[idx] = longint'(p);
    else if (idx <= CFG_DIR_Z) ray_dir[idx - CFG_DIR_X] = longint'(d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         longint dx, longint dy, longint dz);
    cfg_write(CFG_ORG_X, ox);
    cfg_write(CFG_ORG_Y, oy);
    cfg_write(CFG_ORG_Z, oz);
    cfg_write(CFG_DIR_X, dx);
    cfg_write(CFG_DIR_Y, dy);
    cfg_write(CFG_DIR_Z, dz);
  endtask

  task automatic drain();
    while (box_pending.size() > 0 || s_axis_tvalid_i || hit_expected.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] raw_pos();
    return POS_W'({$urandom, $urandom});
  endfunction

  function automatic box_t make_box(bit noise);
    box_t b;
    longint lo[3], hi[3], spread, tmp;
    for (int ax = 0; ax < 3; ax++) begin
      if (noise) begin
        lo[ax] = longint'($signed(raw_pos()));
        hi[ax] = longint'($signed(raw_pos()));
      end else begin
        spread = 64'sd1 << $urandom_range(4, 24);
        lo[ax] = ray_org[ax] + longint'($urandom_range(0, 2 * spread)) - spread;
        hi[ax] = lo[ax] + longint'($urandom_range(0, spread));
        if ($urandom_range(0, 19) == 0) begin
          tmp = lo[ax]; lo[ax] = hi[ax]; hi[ax] = tmp;
        end
      end
    end
    b.min_x = POS_W'(lo[0]); b.min_y = POS_W'(lo[1]); b.min_z = POS_W'(lo[2]);
    b.max_x = POS_W'(hi[0]); b.max_y = POS_W'(hi[1]); b.max_z = POS_W'(hi[2]);
    b.limit = ($urandom_range(0, 7) == 0) ? DIST_W'($urandom)
                                          : DIST_W'($urandom_range(0, 8388608));
    return b;
  endfunction

  function automatic box_t cube(longint lo, longint hi, logic [DIST_W-1:0] lim);
    box_t b;
    b.min_x = POS_W'(lo); b.min_y = POS_W'(lo); b.min_z = POS_W'(lo);
    b.max_x = POS_W'(hi); b.max_y = POS_W'(hi); b.max_z = POS_W'(hi);
    b.limit = lim;
    return b;
  endfunction

  initial begin
    box_t b;
    int n;
    ray_org = '{0, 0, 0};
    ray_dir = '{65536, 0, 0};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset ray: origin 0, direction +x.
    box_pending.push_back(cube(-65536, 65536, 24'd8388608));       // origin inside
    box_pending.push_back(cube(65536, 131072, 24'd8388608));       // y/z slab misses
    b = cube(-65536, 65536, 24'd8388608);
    b.min_x = POS_W'(64'sd327680); b.max_x = POS_W'(64'sd655360);
    box_pending.push_back(b);                                       // ahead, face -x
    b.limit = 24'd327680;
    box_pending.push_back(b);                                       // touching limit
    b.limit = 24'd327679;
    box_pending.push_back(b);                                       // just beyond limit
    b.limit = 24'd0;
    box_pending.push_back(b);
    b.min_x = POS_W'(64'sd655360); b.max_x = POS_W'(64'sd327680);
    b.limit = 24'hFFFFFF;
    box_pending.push_back(b);                                       // inverted on x
    b = cube(-65536, 65536, 24'd8388608);
    b.min_y = POS_W'(64'sd65536); b.max_y = POS_W'(-64'sd65536);
    box_pending.push_back(b);                                       // inverted on zero axis
    b.min_y = '0; b.max_y = '0;
    box_pending.push_back(b);                                       // origin on the bound
    box_pending.push_back(cube(-POS_MAX, POS_MAX, 24'd8388608));
    box_pending.push_back(cube(POS_MAX, -POS_MAX, 24'd8388608));
    box_pending.push_back(cube(37'h1FFFFFFFFF, 37'h0FFFFFFFFF, 24'hFFFFFF));
    box_pending.push_back(cube(37'h1000000000, 37'h0000000000, 24'h000000));
    b = cube(-65536, 65536, 24'd8388608);
    b.min_x = POS_W'(-64'sd20000000000);
    b.max_x = POS_W'(64'sd20000000000);                             // saturating quotient
    box_pending.push_back(b);
    drain();

    // Diagonal ray: equal entries on every axis keep the x face.
    set_ray(-262144, -262144, -262144, 37837, 37837, 37837);
    box_pending.push_back(cube(0, 65536, 24'd8388608));
    b = cube(0, 65536, 24'd8388608);
    b.min_z = POS_W'(64'sd32768);
    box_pending.push_back(b);                                       // z enters last
    b = cube(0, 65536, 24'd8388608);
    b.min_x = POS_W'(-64'sd65536);
    box_pending.push_back(b);
    drain();
    cfg_write(CFG_UNUSED, 64'sd12345);
    set_ray(POS_MAX, -POS_MAX, 0, -65536, 65536, -131072);
    box_pending.push_back(cube(-POS_MAX, POS_MAX, 24'd8388608));
    box_pending.push_back(cube(POS_MAX - 65536, POS_MAX, 24'd8388608));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_ray(0, 0, 0, 65536, 0, 0);
        1: set_ray(0, 0, 0, -65536, 0, 0);
        2: set_ray(131072, -65536, 0, 0, 65536, 0);
        3: set_ray(-1000000, 500000, 0, 0, 0, -65536);
        4: set_ray(100000, -100000, 7, 37837, -37837, 37837);
        5: set_ray(-POS_MAX, POS_MAX, -POS_MAX, 46341, 0, -46341);
        6: set_ray(longint'($signed(raw_pos())), longint'($signed(raw_pos())),
                   longint'($signed(raw_pos())), 131071, -131072, 1);
        default: set_ray(longint'($urandom_range(0, 1 << 24)) - (1 << 23),
                         longint'($urandom_range(0, 1 << 24)) - (1 << 23), 0,
                         longint'($urandom_range(0, 131072)) - 65536,
                         longint'($urandom_range(0, 131072)) - 65536,
                         longint'($urandom_range(0, 131072)) - 65536);
      endcase
      n = 194;
      for (int i = 0; i < n; i++) begin
        if (i % 48 == 0) begin
          send_mode = $urandom_range(0, 2);
          recv_mode = $urandom_range(0, 2);
        end
        box_pending.push_back(make_box($urandom_range(0, 4) == 0));
      end
      if (ph == 3) begin
        // long receiver stall while boxes keep coming
        send_mode = 0;
        hold_off = 400;
      end
      drain();
    end

    $display("sent %0d boxes over 11 ray settings, %0d results checked, %0d hits",
             boxes_sent, results_seen, hits_seen);
    if (mismatches == 0 && hit_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches: %0d, results still owed: %0d", mismatches, hit_expected.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
